// File: rtl/bpc_pkg.sv
// Shared types and constants of the barometric pressure compensation block.
package bpc_pkg;

    // Field widths
    localparam int P_W      = 10;
    localparam int T_W      = 10;
    localparam int COEF_W   = 16;
    localparam int OUT_W    = 16;
    localparam int CFG_IDX_W = 3;

    // Product widths of the front multipliers
    localparam int MUL_W  = COEF_W + T_W + 1;
    localparam int T187_W = 18;

    // Default depth of the queue between front and back
    localparam int QUEUE_DEPTH = 4;

    // Compensation chain shifts
    localparam int SHIFT_A11    = 14;
    localparam int SHIFT_A1     = 11;
    localparam int SHIFT_A2_PRE = 15;
    localparam int SHIFT_A2     = 16;
    localparam int SHIFT_Y1     = 10;
    localparam int SHIFT_PC     = 13;

    // Conversion constants
    localparam logic signed [10:0] HPA_SCALE = 11'sd650;
    localparam int HPA_DIV        = 1023;
    localparam int HPA_BIAS       = 500;
    localparam int DIV1023_RECIP  = 65600;   // floor(2^26 / 1023)
    localparam int DIV1023_SHIFT  = 26;
    localparam int TEMP_SCALE     = 187;
    localparam int DIV100_RECIP   = 335545;  // ceil(2^25 / 100)
    localparam int DIV100_SHIFT   = 25;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_COEF_OFFSET         = 3'd0,
        REG_COEF_PRESSURE_SLOPE = 3'd1,
        REG_COEF_TEMP_SLOPE     = 3'd2,
        REG_COEF_CROSS_PT       = 3'd3,
        REG_COEF_CROSS_PP       = 3'd4,
        REG_COEF_CROSS_TT       = 3'd5,
        REG_TEMP_OFFSET         = 3'd6
    } t_reg_idx;

    typedef struct packed {
        logic signed [COEF_W-1:0] offset;
        logic signed [COEF_W-1:0] pressure_slope;
        logic signed [COEF_W-1:0] temp_slope;
        logic signed [COEF_W-1:0] cross_pt;
        logic signed [COEF_W-1:0] cross_pp;
        logic signed [COEF_W-1:0] cross_tt;
        logic signed [COEF_W-1:0] temp_offset;
    } t_coefs;

    localparam t_coefs COEFS_RESET = '{
        offset:         16'sd0,
        pressure_slope: 16'sd0,
        temp_slope:     16'sd0,
        cross_pt:       16'sd0,
        cross_pp:       16'sd1,
        cross_tt:       16'sd1,
        temp_offset:    16'sd1190
    };

    // One queued work item: counts plus the products the front has formed
    typedef struct packed {
        logic [P_W-1:0]           p;
        logic [T_W-1:0]           t;
        logic signed [MUL_W-1:0]  m_pp;
        logic signed [MUL_W-1:0]  m_pt;
        logic signed [MUL_W-1:0]  m_tt;
        logic [T187_W-1:0]        t187;
    } t_work;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

endpackage

// File: rtl/bpc_in_if.sv
// Input channel: one pair of converter counts with valid/ready.
interface bpc_in_if;
    logic                      valid;
    logic                      ready;
    logic [bpc_pkg::P_W-1:0]   pressure_count;
    logic [bpc_pkg::T_W-1:0]   temperature_count;

    modport source (output valid, output pressure_count, output temperature_count,
                    input ready);
    modport sink   (input valid, input pressure_count, input temperature_count,
                    output ready);
endinterface

// File: rtl/bpc_out_if.sv
// Output channel: compensated count, pressure and temperature with valid/ready.
interface bpc_out_if;
    logic                              valid;
    logic                              ready;
    logic signed [bpc_pkg::OUT_W-1:0]  compensated_count;
    logic signed [bpc_pkg::OUT_W-1:0]  pressure_hpa;
    logic signed [bpc_pkg::OUT_W-1:0]  temperature_tenths;

    modport source (output valid, output compensated_count, output pressure_hpa,
                    output temperature_tenths, input ready);
    modport sink   (input valid, input compensated_count, input pressure_hpa,
                    input temperature_tenths, output ready);
endinterface

// File: rtl/bpc_front.sv
// Front end: accept a sample and form the coefficient-by-count products.
module bpc_front (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  bpc_pkg::t_coefs  i_coefs,
    bpc_in_if.sink           i_sample,
    output logic             o_push_valid,
    input  logic             i_push_ready,
    output bpc_pkg::t_work   o_push_work
);

    logic            r_valid;
    bpc_pkg::t_work  r_work;
    bpc_pkg::t_work  n_work;
    logic signed [bpc_pkg::P_W:0] p_s;
    logic signed [bpc_pkg::T_W:0] t_s;

    // Take a new sample when the slot is empty or drains this cycle
    assign i_sample.ready = !r_valid || i_push_ready;

    always_comb begin
        p_s         = $signed({1'b0, i_sample.pressure_count});
        t_s         = $signed({1'b0, i_sample.temperature_count});
        n_work.p    = i_sample.pressure_count;
        n_work.t    = i_sample.temperature_count;
        n_work.m_pp = i_coefs.cross_pp * p_s;
        n_work.m_pt = i_coefs.cross_pt * t_s;
        n_work.m_tt = i_coefs.cross_tt * t_s;
        n_work.t187 = bpc_pkg::T187_W'(bpc_pkg::TEMP_SCALE)
                      * {{(bpc_pkg::T187_W - bpc_pkg::T_W){1'b0}}, i_sample.temperature_count};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_sample.ready) begin
            r_valid <= i_sample.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_sample.valid && i_sample.ready) begin
            r_work <= n_work;
        end
    end

    assign o_push_valid = r_valid;
    assign o_push_work  = r_work;

endmodule

// File: rtl/bpc_queue.sv
// Short FIFO of work items between front and back.
module bpc_queue #(
    parameter int Depth = bpc_pkg::QUEUE_DEPTH
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push_valid,
    output logic              o_push_ready,
    input  bpc_pkg::t_work    i_push_work,
    output logic              o_pop_valid,
    input  logic              i_pop_ready,
    output bpc_pkg::t_work    o_pop_work,
    output bpc_pkg::t_q_stat  o_stat
);

    localparam int AW = (Depth > 1) ? $clog2(Depth) : 1;
    localparam int CW = $clog2(Depth + 1);

    bpc_pkg::t_work r_mem [Depth];
    logic [AW-1:0]  r_wptr, n_wptr;
    logic [AW-1:0]  r_rptr, n_rptr;
    logic [CW-1:0]  r_count, n_count;
    logic           push, pop;

    assign o_stat.full  = (r_count == CW'(Depth));
    assign o_stat.empty = (r_count == '0);
    assign o_push_ready = !o_stat.full;
    assign o_pop_valid  = !o_stat.empty;
    assign o_pop_work   = r_mem[r_rptr];

    assign push = i_push_valid && !o_stat.full;
    assign pop  = i_pop_ready && !o_stat.empty;

    always_comb begin
        n_wptr  = r_wptr;
        n_rptr  = r_rptr;
        n_count = r_count;
        if (push) begin
            n_wptr = (r_wptr == AW'(Depth - 1)) ? '0 : r_wptr + AW'(1);
        end
        if (pop) begin
            n_rptr = (r_rptr == AW'(Depth - 1)) ? '0 : r_rptr + AW'(1);
        end
        unique case ({push, pop})
            2'b10:   n_count = r_count + CW'(1);
            2'b01:   n_count = r_count - CW'(1);
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wptr] <= i_push_work;
        end
    end

endmodule

// File: rtl/bpc_back.sv
// Back end: nine-stage compensation and conversion pipeline with output register.
module bpc_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  bpc_pkg::t_coefs  i_coefs,
    input  logic             i_pop_valid,
    output logic             o_pop_ready,
    input  bpc_pkg::t_work   i_pop_work,
    bpc_out_if.source        o_result
);

    localparam int NSTG = 9;

    logic            en;
    logic [NSTG-1:0] r_v;

    // Stage 1: a11, a2, temperature quotient
    logic signed [31:0] s1_sum_a11, s1_sum_a2;
    logic [36:0]        s1_tprod;
    logic signed [16:0] r_s1_a11;
    logic signed [15:0] r_s1_a2;
    logic [10:0]        r_s1_tq;
    logic signed [bpc_pkg::MUL_W-1:0] r_s1_m_pt;
    logic [bpc_pkg::P_W-1:0] r_s1_p;
    logic [bpc_pkg::T_W-1:0] r_s1_t;

    // Stage 2: a1, temperature
    logic signed [31:0] s2_sum_a1;
    logic signed [17:0] r_s2_a1;
    logic signed [15:0] r_s2_a2;
    logic [15:0]        r_s2_temp;
    logic [bpc_pkg::P_W-1:0] r_s2_p;
    logic [bpc_pkg::T_W-1:0] r_s2_t;

    // Stage 3: a1 * P
    logic signed [28:0] r_s3_a1p;
    logic signed [15:0] r_s3_a2;
    logic [15:0]        r_s3_temp;
    logic [bpc_pkg::T_W-1:0] r_s3_t;

    // Stage 4: y1, a2 * T
    logic signed [31:0] s4_sum_y1;
    logic signed [18:0] r_s4_y1;
    logic signed [25:0] r_s4_a2t;
    logic [15:0]        r_s4_temp;

    // Stage 5: compensated count
    logic signed [31:0] s5_acc;
    logic signed [15:0] r_s5_pc;
    logic [15:0]        r_s5_temp;

    // Stage 6: 650 * pcomp, split into sign and magnitude
    logic signed [25:0] s6_x;
    logic               r_s6_neg;
    logic [24:0]        r_s6_mag;
    logic signed [15:0] r_s6_pc;
    logic [15:0]        r_s6_temp;

    // Stage 7: quotient estimate by reciprocal
    logic [41:0]        s7_prod;
    logic [14:0]        r_s7_qe;
    logic [24:0]        r_s7_mag;
    logic               r_s7_neg;
    logic signed [15:0] r_s7_pc;
    logic [15:0]        r_s7_temp;

    // Stage 8: one-step correction
    logic [25:0]        s8_rem;
    logic [14:0]        r_s8_q;
    logic               r_s8_neg;
    logic signed [15:0] r_s8_pc;
    logic [15:0]        r_s8_temp;

    // Stage 9: output register
    logic [15:0]        s9_q;
    logic [15:0]        r_s9_hpa;
    logic signed [15:0] r_s9_pc;
    logic [15:0]        r_s9_temp;

    // Freeze the whole pipe while the output register holds an untaken result
    assign en          = !r_v[NSTG-1] || o_result.ready;
    assign o_pop_ready = en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (en) begin
            r_v <= {r_v[NSTG-2:0], i_pop_valid};
        end
    end

    always_comb begin
        s1_sum_a11 = (32'(i_coefs.pressure_slope) <<< bpc_pkg::SHIFT_A11)
                     + 32'(i_pop_work.m_pp);
        s1_sum_a2  = (32'(i_coefs.temp_slope) <<< bpc_pkg::SHIFT_A2_PRE)
                     + 32'(i_pop_work.m_tt >>> 1);
        s1_tprod   = i_pop_work.t187 * 19'(bpc_pkg::DIV100_RECIP);

        s2_sum_a1  = (32'(r_s1_a11) <<< bpc_pkg::SHIFT_A1) + 32'(r_s1_m_pt);

        s4_sum_y1  = (32'(i_coefs.offset) <<< bpc_pkg::SHIFT_Y1) + 32'(r_s3_a1p);

        s5_acc     = (32'(r_s4_y1) <<< bpc_pkg::SHIFT_Y1) + 32'(r_s4_a2t);

        s6_x       = r_s5_pc * bpc_pkg::HPA_SCALE;

        s7_prod    = r_s6_mag * 17'(bpc_pkg::DIV1023_RECIP);

        // Remainder n - q*1023, formed as n - q*1024 + q
        s8_rem     = {1'b0, r_s7_mag} - {1'b0, r_s7_qe, 10'b0} + {11'b0, r_s7_qe};

        s9_q       = {1'b0, r_s8_q};
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s1_a11  <= 17'(s1_sum_a11 >>> bpc_pkg::SHIFT_A11);
            r_s1_a2   <= 16'(s1_sum_a2 >>> bpc_pkg::SHIFT_A2);
            r_s1_tq   <= 11'(s1_tprod >> bpc_pkg::DIV100_SHIFT);
            r_s1_m_pt <= i_pop_work.m_pt;
            r_s1_p    <= i_pop_work.p;
            r_s1_t    <= i_pop_work.t;

            r_s2_a1   <= 18'(s2_sum_a1 >>> bpc_pkg::SHIFT_A1);
            r_s2_a2   <= r_s1_a2;
            r_s2_temp <= $unsigned(i_coefs.temp_offset) - {5'b0, r_s1_tq};
            r_s2_p    <= r_s1_p;
            r_s2_t    <= r_s1_t;

            r_s3_a1p  <= r_s2_a1 * $signed({1'b0, r_s2_p});
            r_s3_a2   <= r_s2_a2;
            r_s3_temp <= r_s2_temp;
            r_s3_t    <= r_s2_t;

            r_s4_y1   <= 19'(s4_sum_y1 >>> bpc_pkg::SHIFT_Y1);
            r_s4_a2t  <= r_s3_a2 * $signed({1'b0, r_s3_t});
            r_s4_temp <= r_s3_temp;

            r_s5_pc   <= 16'(s5_acc >>> bpc_pkg::SHIFT_PC);
            r_s5_temp <= r_s4_temp;

            r_s6_neg  <= s6_x[25];
            r_s6_mag  <= 25'(s6_x[25] ? -s6_x : s6_x);
            r_s6_pc   <= r_s5_pc;
            r_s6_temp <= r_s5_temp;

            r_s7_qe   <= 15'(s7_prod >> bpc_pkg::DIV1023_SHIFT);
            r_s7_mag  <= r_s6_mag;
            r_s7_neg  <= r_s6_neg;
            r_s7_pc   <= r_s6_pc;
            r_s7_temp <= r_s6_temp;

            r_s8_q    <= r_s7_qe + 15'(s8_rem >= 26'(bpc_pkg::HPA_DIV));
            r_s8_neg  <= r_s7_neg;
            r_s8_pc   <= r_s7_pc;
            r_s8_temp <= r_s7_temp;

            r_s9_hpa  <= (r_s8_neg ? (16'd0 - s9_q) : s9_q) + 16'(bpc_pkg::HPA_BIAS);
            r_s9_pc   <= r_s8_pc;
            r_s9_temp <= r_s8_temp;
        end
    end

    assign o_result.valid              = r_v[NSTG-1];
    assign o_result.compensated_count  = r_s9_pc;
    assign o_result.pressure_hpa       = $signed(r_s9_hpa);
    assign o_result.temperature_tenths = $signed(r_s9_temp);

endmodule

// File: rtl/barometric_pressure_compensation.sv
// Top level of the barometric pressure compensation block.
//
//  channel    | dir | payload                                            | handshake
//  -----------+-----+----------------------------------------------------+------------------
//  i_sample   | in  | pressure_count, temperature_count (10b each)       | valid/ready
//  o_result   | out | compensated_count, pressure_hpa, temperature_tenths | valid/ready
//  i_cfg_*    | in  | i_cfg_idx (3b), i_cfg_data (16b)                   | write on i_cfg_we
//
// One sample per cycle sustained while the output is not stalled; a result passes
// the front register, then the queue, then nine back stages that follow
// a11 -> a1 -> a1*P -> y1 -> pcomp and the reciprocal divide by 1023.
// Reset (synchronous, active low) empties front register, queue and pipe and loads
// the coefficient reset values. A stalled output freezes only the back pipe; the
// queue and front register absorb samples until full, then input ready drops.
module barometric_pressure_compensation #(
    parameter int QueueDepth = bpc_pkg::QUEUE_DEPTH
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    bpc_in_if.sink                            i_sample,
    bpc_out_if.source                         o_result,
    input  logic                              i_cfg_we,
    input  logic [bpc_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [bpc_pkg::COEF_W-1:0]        i_cfg_data
);

    // Coefficient registers, to be written only while the block is idle, which the block leaves to the user
    bpc_pkg::t_coefs   r_coefs, n_coefs;

    // Front to queue
    logic              push_valid;
    logic              push_ready;
    bpc_pkg::t_work    push_work;

    // Queue to back
    logic              pop_valid;
    logic              pop_ready;
    bpc_pkg::t_work    pop_work;
    bpc_pkg::t_q_stat  q_stat;

    // Decode a configuration write; drop writes to indexes beyond the list
    always_comb begin
        n_coefs = r_coefs;
        if (i_cfg_we) begin
            unique case (i_cfg_idx)
                bpc_pkg::REG_COEF_OFFSET:         n_coefs.offset         = i_cfg_data;
                bpc_pkg::REG_COEF_PRESSURE_SLOPE: n_coefs.pressure_slope = i_cfg_data;
                bpc_pkg::REG_COEF_TEMP_SLOPE:     n_coefs.temp_slope     = i_cfg_data;
                bpc_pkg::REG_COEF_CROSS_PT:       n_coefs.cross_pt       = i_cfg_data;
                bpc_pkg::REG_COEF_CROSS_PP:       n_coefs.cross_pp       = i_cfg_data;
                bpc_pkg::REG_COEF_CROSS_TT:       n_coefs.cross_tt       = i_cfg_data;
                bpc_pkg::REG_TEMP_OFFSET:         n_coefs.temp_offset    = i_cfg_data;
                default:                          n_coefs                = r_coefs;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coefs <= bpc_pkg::COEFS_RESET;
        end else begin
            r_coefs <= n_coefs;
        end
    end

    // Accept samples and form the products that need only the raw counts
    bpc_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_coefs      (r_coefs),
        .i_sample     (i_sample),
        .o_push_valid (push_valid),
        .i_push_ready (push_ready),
        .o_push_work  (push_work)
    );

    // Decouple the front from output stalls
    bpc_queue #(
        .Depth (QueueDepth)
    ) u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (push_valid),
        .o_push_ready (push_ready),
        .i_push_work  (push_work),
        .o_pop_valid  (pop_valid),
        .i_pop_ready  (pop_ready),
        .o_pop_work   (pop_work),
        .o_stat       (q_stat)
    );

    // Run the compensation chain and the two conversions
    bpc_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_coefs     (r_coefs),
        .i_pop_valid (pop_valid),
        .o_pop_ready (pop_ready),
        .i_pop_work  (pop_work),
        .o_result    (o_result)
    );

`ifndef SYNTHESIS
    // A full queue is never empty in the next cycle
    a_full_not_empty_next: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_stat.full |=> !q_stat.empty)
        else $error("queue went from full to empty in one cycle");

    // An empty queue is never full in the next cycle
    a_empty_not_full_next: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_stat.empty |=> !q_stat.full)
        else $error("queue went from empty to full in one cycle");

    // Reset leaves no result pending
    a_reset_clears_output: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_result.valid)
        else $error("result valid right after reset");
`endif

endmodule

// File: tb/bpc_checker.sv
`timescale 1ns / 1ps
// Checker for the compensation block: predicts each reading and compares it with the output.
module bpc_checker
    import bpc_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    bpc_in_if                    smp,
    bpc_out_if                   res,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [COEF_W-1:0]    i_cfg_data,
    output int                   o_pending,
    output int                   o_errors
);

    localparam int MAX_REPORTS = 10;

    typedef struct {
        logic [P_W-1:0]          p;
        logic [T_W-1:0]          t;
        logic signed [OUT_W-1:0] count;
        logic signed [OUT_W-1:0] hpa;
        logic signed [OUT_W-1:0] tenths;
    } t_reading;

    t_coefs   coefs = COEFS_RESET;
    t_reading readings[$];
    int       errors = 0;

    // Every sum wraps to 32 bits before its arithmetic shift.
    function automatic t_reading compensate(input t_coefs k, input logic [P_W-1:0] pc,
                                            input logic [T_W-1:0] tc);
        longint   p;
        longint   t;
        int       a11;
        int       a1;
        int       a2;
        int       y1;
        int       acc;
        int       scaled;
        int       hpa;
        int       tenths;
        t_reading r;
        p = longint'(pc);
        t = longint'(tc);
        a11 = int'(longint'(k.pressure_slope) * 16384
                   + longint'(int'(longint'(k.cross_pp) * p))) >>> 14;
        a1  = int'(longint'(a11) * 2048 + longint'(int'(longint'(k.cross_pt) * t))) >>> 11;
        a2  = int'(longint'(k.temp_slope) * 32768
                   + longint'(int'(longint'(k.cross_tt) * t) >>> 1)) >>> 16;
        y1  = int'(longint'(k.offset) * 1024 + longint'(int'(longint'(a1) * p))) >>> 10;
        acc = int'(longint'(y1) * 1024 + longint'(int'(longint'(a2) * t)));
        scaled = acc >>> 13;
        r.p = pc;
        r.t = tc;
        r.count = scaled[OUT_W-1:0];
        // integer division truncates toward zero
        hpa    = (650 * int'(r.count)) / 1023 + 500;
        tenths = (-187 * int'(t)) / 100 + int'(k.temp_offset);
        r.hpa    = hpa[OUT_W-1:0];
        r.tenths = tenths[OUT_W-1:0];
        return r;
    endfunction

    task automatic report(input string msg);
        errors++;
        if (errors <= MAX_REPORTS) begin
            $display("%0t ns: %s", $time, msg);
        end
    endtask

    always @(posedge i_clk) begin
        t_reading want;
        if (!i_rst_n) begin
            coefs = COEFS_RESET;
            readings.delete();
        end else begin
            if (res.valid && res.ready) begin
                if (readings.size() == 0) begin
                    report($sformatf("result with nothing outstanding: %0d %0d %0d",
                                     res.compensated_count, res.pressure_hpa,
                                     res.temperature_tenths));
                end else begin
                    want = readings.pop_front();
                    if (res.compensated_count !== want.count)
                        report($sformatf("compensated_count P=%0d T=%0d: expected %0d, got %0d",
                                         want.p, want.t, want.count, res.compensated_count));
                    if (res.pressure_hpa !== want.hpa)
                        report($sformatf("pressure_hpa P=%0d T=%0d: expected %0d, got %0d",
                                         want.p, want.t, want.hpa, res.pressure_hpa));
                    if (res.temperature_tenths !== want.tenths)
                        report($sformatf("temperature_tenths P=%0d T=%0d: expected %0d, got %0d",
                                         want.p, want.t, want.tenths,
                                         res.temperature_tenths));
                end
            end
            if (smp.valid && smp.ready) begin
                readings.push_back(compensate(coefs, smp.pressure_count,
                                              smp.temperature_count));
            end
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_COEF_OFFSET:         coefs.offset         = i_cfg_data;
                    REG_COEF_PRESSURE_SLOPE: coefs.pressure_slope = i_cfg_data;
                    REG_COEF_TEMP_SLOPE:     coefs.temp_slope     = i_cfg_data;
                    REG_COEF_CROSS_PT:       coefs.cross_pt       = i_cfg_data;
                    REG_COEF_CROSS_PP:       coefs.cross_pp       = i_cfg_data;
                    REG_COEF_CROSS_TT:       coefs.cross_tt       = i_cfg_data;
                    REG_TEMP_OFFSET:         coefs.temp_offset    = i_cfg_data;
                    default: ;
                endcase
            end
        end
        o_pending <= readings.size();
        o_errors  <= errors;
    end

endmodule

// File: tb/tb_barometric_pressure_compensation.sv
`timescale 1ns / 1ps
// Top of the compensation testbench: drives samples and coefficients and gives the verdict.
module tb_barometric_pressure_compensation;
    import bpc_pkg::*;

    // Index past the last register: writes to it must leave every coefficient alone.
    localparam logic [CFG_IDX_W-1:0] REG_SPARE = 3'd7;

    localparam int RAND_PHASES   = 12;
    localparam int PHASE_ITEMS   = 160;
    // Cycles to wait after the last result before touching the coefficients or ending.
    localparam int SETTLE_CYCLES = 16;

    // Corner counts: both ends, the mixes, mid-scale and alternating bits.
    localparam logic [P_W-1:0] CORNER_P [8] = '{10'd0, 10'd1023, 10'd0, 10'd1023,
                                                10'd512, 10'd1, 10'h2AA, 10'h155};
    localparam logic [T_W-1:0] CORNER_T [8] = '{10'd0, 10'd1023, 10'd1023, 10'd0,
                                                10'd511, 10'd1, 10'h155, 10'h2AA};

    // A plausible calibrated sensor.
    localparam t_coefs COEFS_TYPICAL = '{
        offset:         16'sd16100,
        pressure_slope: -16'sd19400,
        temp_slope:     -16'sd18000,
        cross_pt:       16'sd900,
        cross_pp:       16'sd3,
        cross_tt:       -16'sd2,
        temp_offset:    16'sd1190
    };
    localparam t_coefs COEFS_MAX = '{default: 16'sh7FFF};
    localparam t_coefs COEFS_MIN = '{default: 16'sh8000};

    logic              i_clk = 1'b0;
    logic              i_rst_n;
    logic              cfg_we;
    logic [CFG_IDX_W-1:0] cfg_idx;
    logic [COEF_W-1:0] cfg_data;
    logic              sink_ready = 1'b0;
    int                stall_pct = 0;
    int                idle_pct = 0;
    int                pending;
    int                errors;

    bpc_in_if  smp_if();
    bpc_out_if res_if();

    assign res_if.ready = sink_ready;

    barometric_pressure_compensation i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_sample   (smp_if),
        .o_result   (res_if),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    bpc_checker i_checker (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .smp        (smp_if),
        .res        (res_if),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .o_pending  (pending),
        .o_errors   (errors)
    );

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    // Stall the output at random; stall_pct of zero keeps ready high.
    always @(posedge i_clk) begin
        sink_ready <= ($urandom_range(99) >= stall_pct);
    end

    // Hard stop in case the block hangs; far beyond the slowest correct run.
    initial begin
        #4_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Sender idle rate is only read by the stimulus thread; the stall rate is
    // read by the ready process at the same edge, so update it nonblocking.
    task automatic set_idling(input int send_pct, input int recv_pct);
        idle_pct = send_pct;
        stall_pct <= recv_pct;
    endtask

    // Offer one sample, with random idle cycles ahead of it, and hold it until
    // the transaction completes. Valid stays high on return so that
    // back-to-back samples need no gap.
    task automatic send_sample(input logic [P_W-1:0] p, input logic [T_W-1:0] t);
        while ($urandom_range(99) < idle_pct) begin
            smp_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        smp_if.valid             <= 1'b1;
        smp_if.pressure_count    <= p;
        smp_if.temperature_count <= t;
        @(posedge i_clk);
        while (!smp_if.ready) @(posedge i_clk);
    endtask

    // Drop valid and wait until every outstanding reading has come out, then
    // let the pipe settle. The outstanding count is registered in the checker,
    // hence the first edge before polling.
    task automatic drain();
        smp_if.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Write every coefficient back to back, then poke the unmapped index with
    // junk. Write enable stays high across the burst and drops once at the end.
    task automatic load_coefs(input t_coefs c);
        logic [COEF_W-1:0] word;
        for (int i = 0; i <= REG_SPARE; i++) begin
            case (t_reg_idx'(i))
                REG_COEF_OFFSET:         word = c.offset;
                REG_COEF_PRESSURE_SLOPE: word = c.pressure_slope;
                REG_COEF_TEMP_SLOPE:     word = c.temp_slope;
                REG_COEF_CROSS_PT:       word = c.cross_pt;
                REG_COEF_CROSS_PP:       word = c.cross_pp;
                REG_COEF_CROSS_TT:       word = c.cross_tt;
                REG_TEMP_OFFSET:         word = c.temp_offset;
                default:                 word = COEF_W'($urandom);
            endcase
            cfg_we   <= 1'b1;
            cfg_idx  <= CFG_IDX_W'(i);
            cfg_data <= word;
            @(posedge i_clk);
        end
        cfg_we <= 1'b0;
    endtask

    // Coefficients lean on the extremes, zero and minus one, where the
    // intermediate sums wrap.
    function automatic logic [COEF_W-1:0] pick_coef();
        case ($urandom_range(7))
            0:       return 16'h7FFF;
            1:       return 16'h8000;
            2:       return 16'h0000;
            3:       return 16'hFFFF;
            default: return COEF_W'($urandom);
        endcase
    endfunction

    // Counts are mostly uniform, with the two ends of the range now and then.
    function automatic logic [P_W-1:0] pick_count();
        if ($urandom_range(7) == 0) begin
            return $urandom_range(1) ? 10'h3FF : 10'h000;
        end
        return P_W'($urandom_range(1023));
    endfunction

    initial begin
        t_coefs set;
        i_rst_n                  <= 1'b0;
        cfg_we                   <= 1'b0;
        cfg_idx                  <= '0;
        cfg_data                 <= '0;
        smp_if.valid             <= 1'b0;
        smp_if.pressure_count    <= '0;
        smp_if.temperature_count <= '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part: corner counts under the reset coefficients, then with
        // every register at its top, then at its bottom. The last two push
        // every sum and the temperature offset through their wrap.
        set_idling(38, 52);
        for (int d = 0; d < 3; d++) begin
            if (d == 1) begin
                drain();
                load_coefs(COEFS_MAX);
            end else if (d == 2) begin
                drain();
                load_coefs(COEFS_MIN);
            end
            for (int i = 0; i < 8; i++) send_sample(CORNER_P[i], CORNER_T[i]);
        end

        // Random part: typical coefficients every sixth phase, a random set otherwise;
        // the idling pattern flips after the first third and is switched off for the last third.
        for (int ph = 0; ph < RAND_PHASES; ph++) begin
            if (ph == RAND_PHASES / 3) begin
                set_idling(52, 38);
            end else if (ph == 2 * RAND_PHASES / 3) begin
                set_idling(0, 0);
            end
            if (ph % 6 == 0) begin
                set = COEFS_TYPICAL;
            end else begin
                set.offset         = pick_coef();
                set.pressure_slope = pick_coef();
                set.temp_slope     = pick_coef();
                set.cross_pt       = pick_coef();
                set.cross_pp       = pick_coef();
                set.cross_tt       = pick_coef();
                set.temp_offset    = pick_coef();
            end
            drain();
            load_coefs(set);
            for (int i = 0; i < PHASE_ITEMS; i++) send_sample(pick_count(), pick_count());
        end

        drain();
        if (errors == 0 && pending == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
